### rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// Frame allocator package
// Request and result layouts, request codes and fixed constants.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int ADDR_W = 40;
  localparam logic [31:0] PINNED = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FN_ALLOC   = 3'd0,
    FN_BELOW   = 3'd1,
    FN_CONTIG  = 3'd2,
    FN_FREE    = 3'd3,
    FN_REF_INC = 3'd4,
    FN_REF_GET = 3'd5,
    FN_PIN     = 3'd6,
    FN_COUNT   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    CR_BASE0   = 3'd0,
    CR_FRAMES0 = 3'd1,
    CR_BASE1   = 3'd2,
    CR_FRAMES1 = 3'd3,
    CR_BASE2   = 3'd4,
    CR_FRAMES2 = 3'd5,
    CR_BASE3   = 3'd6,
    CR_FRAMES3 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    func_t       func;
    logic [39:0] addr;
    logic [39:0] limit;
    logic [16:0] nframes;
    logic [40:0] align;
    logic [39:0] length;
  } rfa_in_t;

  typedef struct packed {
    logic [39:0] result_addr;
    logic [31:0] ref_value;
    logic [16:0] free_count;
    logic [16:0] managed_count;
  } rfa_out_t;

endpackage

### rtl/refcounted_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// Reference-counted frame allocator
// Used bit and reference count per frame in one memory, handled by a
// read-modify-write sequencer that walks frames one at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  in_       request    in_valid/in_stall   rfa_in_t
//  out_      result     out_valid/out_stall rfa_out_t
//  cfg_      write      cfg_we              cfg_index, cfg_data
//
// Scans read the frames one at a time through the single memory read port,
// and a contiguous allocation then writes each frame of the run it found.
// After reset a clearing pass over all FRAMES entries runs before the first
// request is taken. A finished result waits in the output register while the
// next request is taken.
module refcounted_frame_allocator_unit #(
  parameter int FRAMES     = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int REGIONS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfa_pkg::rfa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rfa_pkg::rfa_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [39:0]       cfg_data
);
  import rfa_pkg::*;

  localparam int AW = 42;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SW = ((CW > 19) ? CW : 19) + 1;
  localparam logic [AW-1:0] PAGE = AW'(1) << PAGE_SHIFT;
  localparam logic [AW-1:0] PMASK = PAGE - AW'(1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_LK1, ST_LK2, ST_LK3, ST_RMW_RD,
    ST_RMW_WR, ST_SC_RD, ST_SC_CK, ST_RUN_WR, ST_PIN_Q, ST_DONE
  } st_t;

  st_t               state_r, state_nxt;
  rfa_in_t           req_r, req_nxt;
  rfa_out_t          res_r, res_nxt;
  rfa_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       base_r [4];
  logic [16:0]       frm_r [4];
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     la_r, la_nxt;
  logic              lk_hit_r, lk_hit_nxt;
  logic [1:0]        lk_sel_r, lk_sel_nxt;
  logic [SW-1:0]     lk_idx_r, lk_idx_nxt;
  logic [CW-1:0]     sc_i_r, sc_i_nxt;
  logic [1:0]        sc_reg_r, sc_reg_nxt;
  logic [16:0]       sc_off_r, sc_off_nxt;
  logic              run_on_r, run_on_nxt;
  logic [16:0]       run_cnt_r, run_cnt_nxt;
  logic [AW-1:0]     run_addr_r, run_addr_nxt;
  logic [16:0]       run_rem_r, run_rem_nxt;
  logic [CW-1:0]     wi_r, wi_nxt;
  logic [CW-1:0]     free_cnt_r, free_cnt_nxt;

  logic [32:0]       mem [FRAMES];
  logic [32:0]       rd_q;
  logic              mem_we;
  logic [IW-1:0]     mem_wa, mem_ra;
  logic [32:0]       mem_wd;

  logic [16:0]       fr [4];
  logic [SW-1:0]     skip [4];
  logic [SW-1:0]     sum;
  logic [CW-1:0]     total;
  logic [1:0]        first_reg, next_reg;
  logic [AW-1:0]     fa;
  logic [40:0]       al, almask;
  logic              bad_run;
  logic [AW-1:0]     lim, a0, pend, q;
  logic              adv;
  logic              lk_ok;
  logic              hit;
  logic [1:0]        sel;
  logic [AW-1:0]     rend;
  logic              cand_ok;
  logic [31:0]       refc;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      fr[r] = (r < REGIONS) ? frm_r[r] : 17'd0;
    end
    skip[0] = '0;
    for (int r = 1; r < 4; r++) begin
      skip[r] = skip[r-1] + SW'(fr[r-1]);
    end
    sum = skip[3] + SW'(fr[3]);
    total = (sum > SW'(FRAMES)) ? CW'(FRAMES) : CW'(sum);
    first_reg = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      if (fr[r] != 17'd0) first_reg = 2'(r);
    end
    next_reg = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      if (fr[r] != 17'd0 && 2'(r) > sc_reg_r) next_reg = 2'(r);
    end
    fa = AW'(base_r[sc_reg_r]) + (AW'(sc_off_r) << PAGE_SHIFT);
    al = (req_r.align == 41'd0) ? PAGE[40:0] : req_r.align;
    almask = al - 41'd1;
    bad_run = (req_r.nframes == 17'd0) || ((al & almask) != 41'd0) ||
              ((al & PMASK[40:0]) != 41'd0) || (CW'(req_r.nframes) > total) ||
              (SW'(req_r.nframes) > SW'(total));
    lim = (req_r.func == FN_BELOW) ? AW'(req_r.limit) : (AW'(1) << ADDR_W);
    a0 = AW'(req_r.addr) & ~PMASK;
    pend = AW'(req_r.addr) + AW'(req_r.length);
    q = (fa + PMASK) & ~PMASK;
    cand_ok = ((fa & AW'(almask)) == '0) && (fa != '0) && (fa[AW-1:ADDR_W] == '0);
    hit = 1'b0;
    sel = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      rend = AW'(base_r[r]) + (AW'(fr[r]) << PAGE_SHIFT);
      if (la_r >= AW'(base_r[r]) && la_r < rend) begin
        hit = 1'b1;
        sel = 2'(r);
      end
    end
    lk_ok = lk_hit_r && (lk_idx_r < SW'(total));
    refc = rd_q[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    clr_nxt = clr_r;
    la_nxt = la_r;
    lk_hit_nxt = lk_hit_r;
    lk_sel_nxt = lk_sel_r;
    lk_idx_nxt = lk_idx_r;
    sc_i_nxt = sc_i_r;
    sc_reg_nxt = sc_reg_r;
    sc_off_nxt = sc_off_r;
    run_on_nxt = run_on_r;
    run_cnt_nxt = run_cnt_r;
    run_addr_nxt = run_addr_r;
    run_rem_nxt = run_rem_r;
    wi_nxt = wi_r;
    free_cnt_nxt = free_cnt_r;
    mem_we = 1'b0;
    mem_wa = sc_i_r[IW-1:0];
    mem_wd = '0;
    mem_ra = sc_i_r[IW-1:0];
    adv = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(FRAMES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        sc_i_nxt = '0;
        sc_reg_nxt = first_reg;
        sc_off_nxt = '0;
        run_on_nxt = 1'b0;
        free_cnt_nxt = '0;
        la_nxt = AW'(req_r.addr);
        case (req_r.func) inside
          FN_ALLOC, FN_BELOW, FN_COUNT: state_nxt = ST_SC_RD;
          FN_CONTIG: state_nxt = bad_run ? ST_DONE : ST_SC_RD;
          FN_PIN: state_nxt = (req_r.length == 40'd0) ? ST_DONE : ST_PIN_Q;
          default: state_nxt = ST_LK1;
        endcase
      end
      ST_LK1: begin
        lk_hit_nxt = hit && (la_r != '0);
        lk_sel_nxt = sel;
        state_nxt = ST_LK2;
      end
      ST_LK2: begin
        lk_idx_nxt = skip[lk_sel_r] +
                     SW'((la_r - AW'(base_r[lk_sel_r])) >> PAGE_SHIFT);
        state_nxt = ST_LK3;
      end
      ST_LK3: begin
        if (req_r.func == FN_PIN) begin
          if (lk_ok && lk_idx_r == SW'(sc_i_r)) begin
            mem_we = 1'b1;
            mem_wd = {1'b1, PINNED};
          end
          adv = 1'b1;
          state_nxt = ST_PIN_Q;
        end else begin
          state_nxt = lk_ok ? ST_RMW_RD : ST_DONE;
        end
      end
      ST_RMW_RD: begin
        mem_ra = lk_idx_r[IW-1:0];
        state_nxt = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_wa = lk_idx_r[IW-1:0];
        mem_wd = rd_q;
        case (req_r.func)
          FN_FREE: begin
            mem_we = 1'b1;
            if (refc == PINNED) mem_wd = rd_q;
            else if (refc > 32'd1) mem_wd = {rd_q[32], refc - 32'd1};
            else mem_wd = '0;
          end
          FN_REF_INC: begin
            mem_we = 1'b1;
            if (refc < PINNED - 32'd1) mem_wd = {rd_q[32], refc + 32'd1};
          end
          default: res_nxt.ref_value = refc;
        endcase
        state_nxt = ST_DONE;
      end
      ST_SC_RD: begin
        if (sc_i_r == total) begin
          if (req_r.func == FN_COUNT) begin
            res_nxt.free_count = 17'(free_cnt_r);
            res_nxt.managed_count = 17'(total);
          end
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SC_CK;
        end
      end
      ST_SC_CK: begin
        adv = 1'b1;
        state_nxt = ST_SC_RD;
        case (req_r.func)
          FN_COUNT: begin
            if (!rd_q[32]) free_cnt_nxt = free_cnt_r + CW'(1);
          end
          FN_CONTIG: begin
            if (rd_q[32]) begin
              run_on_nxt = 1'b0;
            end else if (run_on_r) begin
              run_cnt_nxt = run_cnt_r + 17'd1;
              if (run_cnt_r + 17'd1 == req_r.nframes) begin
                state_nxt = ST_RUN_WR;
                run_rem_nxt = req_r.nframes;
              end
            end else if (cand_ok) begin
              run_on_nxt = 1'b1;
              run_cnt_nxt = 17'd1;
              run_addr_nxt = fa;
              wi_nxt = sc_i_r;
              if (req_r.nframes == 17'd1) begin
                state_nxt = ST_RUN_WR;
                run_rem_nxt = req_r.nframes;
              end
            end
          end
          default: begin
            if (!rd_q[32] && fa != '0 && fa[AW-1:ADDR_W] == '0 && fa < lim) begin
              mem_we = 1'b1;
              mem_wd = {1'b1, 32'd1};
              res_nxt.result_addr = fa[ADDR_W-1:0];
              adv = 1'b0;
              state_nxt = ST_DONE;
            end
          end
        endcase
      end
      ST_RUN_WR: begin
        mem_we = 1'b1;
        mem_wa = wi_r[IW-1:0];
        mem_wd = {1'b1, 32'd1};
        wi_nxt = wi_r + CW'(1);
        run_rem_nxt = run_rem_r - 17'd1;
        if (run_rem_r == 17'd1) begin
          res_nxt.result_addr = run_addr_r[ADDR_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_PIN_Q: begin
        if (sc_i_r == total) begin
          state_nxt = ST_DONE;
        end else if (q < a0 || q >= pend) begin
          adv = 1'b1;
        end else begin
          la_nxt = q;
          state_nxt = ST_LK1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      sc_i_nxt = sc_i_r + CW'(1);
      if (sc_off_r + 17'd1 == fr[sc_reg_r]) begin
        sc_reg_nxt = next_reg;
        sc_off_nxt = '0;
        run_on_nxt = 1'b0;
      end else begin
        sc_off_nxt = sc_off_r + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      out_valid_r <= 1'b0;
      clr_r <= '0;
      for (int r = 0; r < 4; r++) begin
        base_r[r] <= '0;
        frm_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r <= clr_nxt;
      if (cfg_we) begin
        if (cfg_index[0]) frm_r[cfg_index[2:1]] <= cfg_data[16:0];
        else base_r[cfg_index[2:1]] <= cfg_data;
      end
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    la_r <= la_nxt;
    lk_hit_r <= lk_hit_nxt;
    lk_sel_r <= lk_sel_nxt;
    lk_idx_r <= lk_idx_nxt;
    sc_i_r <= sc_i_nxt;
    sc_reg_r <= sc_reg_nxt;
    sc_off_r <= sc_off_nxt;
    run_on_r <= run_on_nxt;
    run_cnt_r <= run_cnt_nxt;
    run_addr_r <= run_addr_nxt;
    run_rem_r <= run_rem_nxt;
    wi_r <= wi_nxt;
    free_cnt_r <= free_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r) else $error("result during clear");
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN_WR |-> run_rem_r != 17'd0) else $error("empty run write");
  a_write_managed: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |-> (CW'(mem_wa) < total))
    else $error("write beyond managed frames");
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_stall) |=> out_valid_r)
    else $error("finished request not presented");

endmodule
